// File: rtl/sts_pkg.sv
// Shared types and constants for the sine Taylor partial-sum block.
package sts_pkg;

    // Width of term_count and term_index, and the depth of the reciprocal table.
    localparam int TERM_IDX_W = 4;
    localparam int TERM_SLOTS = 1 << TERM_IDX_W;

    // Register reset value of term_count.
    localparam logic [TERM_IDX_W-1:0] TERM_COUNT_RESET = 4'd10;

    // pi with 60 fraction bits; the top level rounds it to its own format.
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // Extra integer bits of a magnitude: every product magnitude stays below 64.
    localparam int MAG_INT_BITS = 6;

    // Phase controls of the shared multiplier.
    typedef struct packed {
        logic lo;   // load low partial product plus rounding constant
        logic hi;   // add high partial product
    } t_mul_ctl;

endpackage

// File: rtl/sts_ifs.sv
// Stream and configuration interfaces of the sine Taylor partial-sum block.
interface sts_in_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface sts_out_if import sts_pkg::*; #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] partial_sum;
    logic [TERM_IDX_W-1:0]        term_index;
    logic                         last;

    modport source (output valid, output partial_sum, output term_index, output last,
                    input ready);
    modport sink   (input valid, input partial_sum, input term_index, input last,
                    output ready);
endinterface

interface sts_cfg_if import sts_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [TERM_IDX_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sts_mul.sv
// Shared two-pass unsigned multiplier with round-half-up rescaling.
module sts_mul import sts_pkg::*; #(
    parameter int MAG_W     = 34,
    parameter int FRAC_BITS = 28
) (
    input  logic             i_clk,
    input  t_mul_ctl         i_ctl,
    input  logic [MAG_W-1:0] i_a,
    input  logic [MAG_W-1:0] i_b,
    output logic [MAG_W-1:0] o_res
);
    localparam int HW = (MAG_W + 1) / 2;
    localparam int AW = 2 * MAG_W;
    localparam int PW = MAG_W + HW;
    localparam logic [AW-1:0] RND = AW'(1) << (FRAC_BITS - 1);

    logic [MAG_W-1:0] r_a;
    logic [HW-1:0]    r_bhi;
    logic [AW-1:0]    r_acc;
    logic [MAG_W-1:0] w_ma;
    logic [HW-1:0]    w_mb;
    logic [PW-1:0]    w_pp;

    // low pass takes the live operands, high pass the held ones
    assign w_ma = i_ctl.hi ? r_a : i_a;
    assign w_mb = i_ctl.hi ? r_bhi : i_b[HW-1:0];
    assign w_pp = PW'(w_ma) * PW'(w_mb);

    always_ff @(posedge i_clk) begin
        if (i_ctl.lo) begin
            r_a   <= i_a;
            r_bhi <= HW'(i_b[MAG_W-1:HW]);
            r_acc <= AW'(w_pp) + RND;
        end else if (i_ctl.hi) begin
            r_acc <= r_acc + (AW'(w_pp) << HW);
        end
    end

    assign o_res = r_acc[FRAC_BITS +: MAG_W];

endmodule

// File: rtl/sine_taylor_partial_sums.sv
// Sine by running partial sums of its Maclaurin series, one result per term.
//
// An angle in signed fixed point (FRAC_BITS fraction bits, Q3.28 by default)
// is clamped to +-pi and the series x - x^3/3! + x^5/5! - ... is summed term
// by term; after each term the running sum leaves on the output channel with
// the term index, and the final sum of the angle carries last. Each term is
// the previous one times x*x times the constant 1/((2j)(2j+1)); every product
// is rounded half away from zero to FRAC_BITS fractions, and every sum
// saturates to the DATA_WIDTH range. term_count (reset 10) sets the number of
// terms: zero counts as one, values above MAX_TERMS as MAX_TERMS. Write it only
// while the block is idle. One multiplier is shared by all products and takes
// two passes per product, so each term after the first costs two products
// and one add. A waiting result sits in the output register while the next
// term is computed; the input is not ready until the last sum of the angle is
// loaded.
module sine_taylor_partial_sums import sts_pkg::*; #(
    parameter int MAX_TERMS  = 10,
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sts_in_if.sink  i_angle,
    sts_out_if.source o_sum,
    sts_cfg_if.sink i_cfg
);
    localparam int MW = FRAC_BITS + MAG_INT_BITS;
    localparam int SW = ((DATA_WIDTH > MW) ? DATA_WIDTH : MW) + 2;

    // pi rounded to the data format, saturated if it does not fit
    localparam logic [63:0] PI_RAW =
        (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [63:0] DMAX64 = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
    localparam logic [63:0] PI_SAT = (PI_RAW > DMAX64) ? DMAX64 : PI_RAW;
    localparam logic signed [DATA_WIDTH-1:0] PI_S     = DATA_WIDTH'(PI_SAT);
    localparam logic signed [DATA_WIDTH-1:0] NEG_PI_S = -PI_S;

    localparam logic signed [DATA_WIDTH-1:0] DMAX = DATA_WIDTH'(DMAX64);
    localparam logic signed [DATA_WIDTH-1:0] DMIN = ~DMAX;
    localparam logic signed [SW-1:0]         SAT_HI = SW'(DMAX);
    localparam logic signed [SW-1:0]         SAT_LO = SW'(DMIN);

    typedef enum logic [3:0] {
        S_IDLE, S_X2_LO, S_X2_HI, S_FIRST,
        S_MA_LO, S_MA_HI, S_MB_LO, S_MB_HI, S_ADD
    } t_state;

    t_state                       r_state;
    logic [TERM_IDX_W-1:0]        r_term_count;
    logic [TERM_IDX_W-1:0]        r_j;
    logic [TERM_IDX_W-1:0]        r_jlast;
    logic [MW-1:0]                r_xmag;
    logic                         r_xneg;
    logic [MW-1:0]                r_x2;
    logic [MW-1:0]                r_term;
    logic signed [DATA_WIDTH-1:0] r_sum;
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_sum;
    logic [TERM_IDX_W-1:0]        r_out_idx;
    logic                         r_out_last;

    logic [MW-1:0]                w_recip [TERM_SLOTS];
    t_mul_ctl                     w_ctl;
    logic [MW-1:0]                w_ma;
    logic [MW-1:0]                w_mb;
    logic [MW-1:0]                w_res;
    logic                         w_accept;
    logic                         w_slot;
    logic                         w_load;
    logic signed [DATA_WIDTH-1:0] w_xc;
    logic signed [SW-1:0]         w_xc_ext;
    logic [MW-1:0]                w_xc_mag;
    logic [TERM_IDX_W:0]          w_n;
    logic [MW-1:0]                w_add_mag;
    logic signed [SW-1:0]         w_term_s;
    logic signed [SW-1:0]         w_raw;
    logic signed [DATA_WIDTH-1:0] w_sat;
    logic                         w_is_last;

    // reciprocals round(2^F / ((2j)(2j+1))); slot zero is never used
    assign w_recip[0] = '0;
    for (genvar g = 1; g < TERM_SLOTS; g++) begin : g_recip
        localparam longint unsigned D = (2 * g) * (2 * g + 1);
        localparam longint unsigned R = ((64'd1 << FRAC_BITS) + D / 2) / D;
        assign w_recip[g] = MW'(R);
    end

    // configuration: always ready, plain register write
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= TERM_COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_term_count <= i_cfg.data;
        end
    end

    assign i_angle.ready = (r_state == S_IDLE);
    assign w_accept      = i_angle.valid && (r_state == S_IDLE);
    assign w_slot        = !r_out_valid || o_sum.ready;
    assign w_load        = ((r_state == S_FIRST) || (r_state == S_ADD)) && w_slot;

    // clamp the angle to +-pi and split it into sign and magnitude
    always_comb begin
        priority if (i_angle.angle > PI_S) begin
            w_xc = PI_S;
        end else if (i_angle.angle < NEG_PI_S) begin
            w_xc = NEG_PI_S;
        end else begin
            w_xc = i_angle.angle;
        end
    end

    assign w_xc_ext = SW'(w_xc);
    assign w_xc_mag = w_xc_ext[SW-1] ? MW'(-w_xc_ext) : MW'(w_xc_ext);

    // effective term count, 1..MAX_TERMS
    always_comb begin
        priority if (r_term_count == '0) begin
            w_n = (TERM_IDX_W+1)'(1);
        end else if ({1'b0, r_term_count} > (TERM_IDX_W+1)'(MAX_TERMS)) begin
            w_n = (TERM_IDX_W+1)'(MAX_TERMS);
        end else begin
            w_n = {1'b0, r_term_count};
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        w_ctl = '0;
        w_ma  = r_xmag;
        w_mb  = r_xmag;
        unique case (r_state)
            S_X2_LO: w_ctl.lo = 1'b1;
            S_X2_HI: w_ctl.hi = 1'b1;
            S_MA_LO: begin
                w_ctl.lo = 1'b1;
                w_ma     = r_term;
                w_mb     = r_x2;
            end
            S_MA_HI: w_ctl.hi = 1'b1;
            S_MB_LO: begin
                w_ctl.lo = 1'b1;
                w_ma     = w_res;
                w_mb     = w_recip[r_j];
            end
            S_MB_HI: w_ctl.hi = 1'b1;
            default: w_ctl = '0;
        endcase
    end

    sts_mul #(
        .MAG_W     (MW),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_res (w_res)
    );

    // add or subtract the new term; it carries the sign of x throughout
    assign w_add_mag = (r_state == S_FIRST) ? r_xmag : w_res;
    assign w_term_s  = r_xneg ? -$signed({{(SW-MW){1'b0}}, w_add_mag})
                              :  $signed({{(SW-MW){1'b0}}, w_add_mag});
    assign w_raw     = r_j[0] ? (SW'(r_sum) - w_term_s) : (SW'(r_sum) + w_term_s);

    always_comb begin
        priority if (w_raw > SAT_HI) begin
            w_sat = DMAX;
        end else if (w_raw < SAT_LO) begin
            w_sat = DMIN;
        end else begin
            w_sat = w_raw[DATA_WIDTH-1:0];
        end
    end

    assign w_is_last = (r_j == r_jlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // load the output with each new sum, drop it once it transfers
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_sum.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_xmag  <= w_xc_mag;
                        r_xneg  <= w_xc[DATA_WIDTH-1];
                        r_sum   <= '0;
                        r_j     <= '0;
                        r_jlast <= TERM_IDX_W'(w_n - (TERM_IDX_W+1)'(1));
                        r_state <= S_X2_LO;
                    end
                end
                S_X2_LO: r_state <= S_X2_HI;
                S_X2_HI: r_state <= S_FIRST;
                S_MA_LO: r_state <= S_MA_HI;
                S_MA_HI: r_state <= S_MB_LO;
                S_MB_LO: r_state <= S_MB_HI;
                S_MB_HI: r_state <= S_ADD;
                S_FIRST, S_ADD: begin
                    // hold here until the output register can take the sum
                    if (w_slot) begin
                        if (r_state == S_FIRST) begin
                            r_x2 <= w_res;
                        end
                        r_term      <= w_add_mag;
                        r_sum       <= w_sat;
                        r_out_sum   <= w_sat;
                        r_out_idx   <= r_j;
                        r_out_last  <= w_is_last;
                        if (w_is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + TERM_IDX_W'(1);
                            r_state <= S_MA_LO;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sum.valid       = r_out_valid;
    assign o_sum.partial_sum = r_out_sum;
    assign o_sum.term_index  = r_out_idx;
    assign o_sum.last        = r_out_last;

endmodule

// File: rtl/sts_chk.sv
// Port-level assertions for the sine Taylor partial-sum block, with its bind.
module sts_chk import sts_pkg::*; #(
    parameter int MAX_TERMS  = 10,
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [DATA_WIDTH-1:0] i_out_sum,
    input logic [TERM_IDX_W-1:0] i_out_idx,
    input logic                  i_out_last
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_sum) && $stable(i_out_idx) && $stable(i_out_last))
        else $error("stalled result changed");

    // the block is busy right after taking an angle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // no new angle while the current one still has sums to come
    a_no_in_mid_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready before the last sum");

    // term index stays inside the configured maximum
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ({1'b0, i_out_idx} < (TERM_IDX_W+1)'(MAX_TERMS)))
        else $error("term index beyond maximum");

endmodule

bind sine_taylor_partial_sums sts_chk #(
    .MAX_TERMS  (MAX_TERMS),
    .DATA_WIDTH (DATA_WIDTH)
) u_sts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_angle.valid),
    .i_in_ready  (i_angle.ready),
    .i_out_valid (o_sum.valid),
    .i_out_ready (o_sum.ready),
    .i_out_sum   (o_sum.partial_sum),
    .i_out_idx   (o_sum.term_index),
    .i_out_last  (o_sum.last)
);

// File: sim/sine_taylor_partial_sums_tb.sv
// Self-checking testbench for sine_taylor_partial_sums: directed and random angles.
module sine_taylor_partial_sums_tb import sts_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TERMS  = 10;
    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 28;

    localparam int MAX_WAIT       = 18;    // longest per-transfer gap on either side
    localparam int HOLD_CYCLES    = 300;   // long output hold-off of the pressure test
    localparam int DRAIN_CYCLES   = 60;    // watch window for stray sums after the drain
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_ANGLES   = 29;

    typedef logic signed [63:0] t_s64;

    // pi rounded to FRAC_BITS fraction bits, and its value as an angle
    localparam logic [63:0] PI_FIX =
        (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam int PI_INT = int'(PI_FIX);

    typedef struct packed {
        logic signed [DATA_W-1:0] partial_sum;
        logic [TERM_IDX_W-1:0]    term_index;
        logic                     last;
    } t_sum_item;

    logic i_clk;
    logic i_rst_n;

    sts_in_if  #(.DATA_WIDTH(DATA_W)) angle_ch ();
    sts_out_if #(.DATA_WIDTH(DATA_W)) sum_ch ();
    sts_cfg_if                        cfg_ch ();

    sine_taylor_partial_sums #(
        .MAX_TERMS (MAX_TERMS),
        .DATA_WIDTH(DATA_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_angle(angle_ch),
        .o_sum  (sum_ch),
        .i_cfg  (cfg_ch)
    );

    // Shadow of the one register, and the sums still owed by the block.
    logic [TERM_IDX_W-1:0] term_count_q;
    t_sum_item             expected_sums[$];
    int                    mismatches;

    // Idle controls: per-side gaps on or off, and the long output hold-off.
    bit send_gaps;
    bit recv_gaps;
    bit hold_off;
    int stall_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Series predictor
    // ------------------------------------------------------------------

    // Exact product of magnitudes, rounded half away from zero to FRAC_BITS.
    function automatic t_s64 mul_round_q(t_s64 a, t_s64 b);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [63:0]  mag;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = 128'(ua) * 128'(ub);
        prod = prod + (128'd1 << (FRAC_BITS - 1));
        mag  = prod[FRAC_BITS +: 64] & 64'h3FFF_FFFF_FFFF_FFFF;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic t_s64 clamp_to_word(t_s64 v);
        t_s64 top;
        top = (t_s64'(1) <<< (DATA_W - 1)) - 1;
        if (v > top)
            return top;
        if (v < -top - 1)
            return -top - 1;
        return v;
    endfunction

    // Push the partial sums that one accepted angle must produce.
    function automatic void predict_partial_sums(logic signed [DATA_W-1:0] angle);
        t_s64        x;
        t_s64        x_sq;
        t_s64        term;
        t_s64        sum;
        logic [63:0] denom;
        logic [63:0] recip;
        int          n_terms;
        t_sum_item   item;
        x = t_s64'(angle);
        if (x > t_s64'(PI_FIX))
            x = PI_FIX;
        if (x < -t_s64'(PI_FIX))
            x = -t_s64'(PI_FIX);
        // a zero count still yields one sum; counts above MAX_TERMS saturate
        n_terms = (term_count_q == 0) ? 1 : int'(term_count_q);
        if (n_terms > MAX_TERMS)
            n_terms = MAX_TERMS;
        x_sq = mul_round_q(x, x);
        term = x;
        sum  = 0;
        for (int j = 0; j < n_terms; j++) begin
            if (j > 0) begin
                denom = 64'(2 * j) * 64'(2 * j + 1);
                recip = ((64'd1 << FRAC_BITS) + denom / 2) / denom;
                term  = mul_round_q(mul_round_q(term, x_sq), $signed(recip));
            end
            sum = clamp_to_word((j % 2 == 0) ? sum + term : sum - term);
            item.partial_sum = sum[DATA_W-1:0];
            item.term_index  = TERM_IDX_W'(j);
            item.last        = (j == n_terms - 1);
            expected_sums.push_back(item);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Compare each sum transfer with the oldest expectation, field by field,
    // then draw how long the output stays stalled before the next one.
    always @(posedge i_clk) begin
        t_sum_item want;
        if (i_rst_n && sum_ch.valid && sum_ch.ready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected sum %0d index %0d last %0b",
                    sum_ch.partial_sum, sum_ch.term_index, sum_ch.last));
            end else begin
                want = expected_sums.pop_front();
                if (sum_ch.partial_sum !== want.partial_sum)
                    report_mismatch($sformatf("partial_sum %0d, want %0d (index %0d)",
                        sum_ch.partial_sum, want.partial_sum, want.term_index));
                if (sum_ch.term_index !== want.term_index)
                    report_mismatch($sformatf("term_index %0d, want %0d",
                        sum_ch.term_index, want.term_index));
                if (sum_ch.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b (index %0d)",
                        sum_ch.last, want.last, want.term_index));
            end
            stall_left = recv_gaps ? $urandom_range(0, MAX_WAIT) : 0;
        end
    end

    // Output side: drop ready while a stall or the long hold-off is running.
    initial begin
        sum_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off || stall_left > 0) begin
                sum_ch.ready <= 1'b0;
                if (!hold_off)
                    stall_left--;
            end else begin
                sum_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((angle_ch.valid && angle_ch.ready) || (sum_ch.valid && sum_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one angle after a random gap, if send_gaps is set, and return at the edge of its transfer.
    // valid stays high into the next angle when that one draws no gap.
    task automatic send_angle(input logic signed [DATA_W-1:0] angle);
        int gap;
        gap = send_gaps ? $urandom_range(0, MAX_WAIT) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            angle_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        angle_ch.valid <= 1'b1;
        angle_ch.angle <= angle;
        do @(posedge i_clk); while (!angle_ch.ready);
        predict_partial_sums(angle);
    endtask

    task automatic stop_angles();
        @(negedge i_clk);
        angle_ch.valid <= 1'b0;
    endtask

    // Write term_count once every owed sum has come out.
    task automatic set_term_count(input logic [TERM_IDX_W-1:0] value);
        stop_angles();
        while (expected_sums.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        term_count_q = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] random_angle();
        int near_pi;
        case ($urandom_range(0, 7))
            2, 3, 4: return int'($urandom_range(0, 2 * PI_INT)) - PI_INT;
            5:       return int'($urandom_range(0, 1 << 20)) - (1 << 19);
            6: begin
                near_pi = PI_INT - 4 + int'($urandom_range(0, 8));
                return $urandom_range(0, 1) ? near_pi : -near_pi;
            end
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The reset count of ten terms, on zero and both ends of the valid range.
    task automatic test_reset_count();
        send_angle('0);
        send_angle(PI_INT);
        send_angle(-PI_INT);
    endtask

    // Word extremes, 4.0 and angles just past pi clamp; small angles and pi/2 do not.
    task automatic test_angle_extremes();
        send_angle(32'sh7FFF_FFFF);
        send_angle(32'sh8000_0000);
        send_angle(PI_INT + 1);
        send_angle(-PI_INT - 1);
        send_angle(32'sh4000_0000);
        send_angle(32'sd1);
        send_angle(-32'sd1);
        send_angle(32'sh1921_FB54);
        send_angle(-32'sh1921_FB54);
    endtask

    // A zero count acts as one term, fifteen saturates to MAX_TERMS.
    task automatic test_term_count_edges();
        set_term_count(4'd0);
        send_angle(PI_INT);
        send_angle(-32'sd1);
        set_term_count(4'd1);
        send_angle(32'sh1234_5678);
        set_term_count(4'd15);
        send_angle(PI_INT);
        send_angle(-PI_INT);
    endtask

    // Hold the output off long enough that the block backs up into its input.
    task automatic test_output_backpressure();
        set_term_count(4'd3);
        fork
            begin
                @(posedge i_clk);
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        send_gaps = 1'b0;
        repeat (16) send_angle(random_angle());
        send_gaps = 1'b1;
    endtask

    // Random angles in phases, each with its own count and idle pattern.
    task automatic test_random_angles();
        logic [TERM_IDX_W-1:0] count;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       count = 4'd1;
                1:       count = 4'd10;
                2:       count = 4'd15;
                3:       count = 4'd0;
                default: count = TERM_IDX_W'($urandom_range(0, 15));
            endcase
            set_term_count(count);
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ANGLES) send_angle(random_angle());
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        angle_ch.valid = 1'b0;
        angle_ch.angle = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        term_count_q   = TERM_COUNT_RESET;
        mismatches     = 0;
        send_gaps      = 1'b1;
        recv_gaps      = 1'b1;
        hold_off       = 1'b0;
        stall_left     = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_count();
        test_angle_extremes();
        test_term_count_edges();
        test_output_backpressure();
        test_random_angles();

        // drain what is owed, then watch for stray sums
        stop_angles();
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sine_taylor_partial_sums.f
rtl/sts_pkg.sv
rtl/sts_ifs.sv
rtl/sts_mul.sv
rtl/sine_taylor_partial_sums.sv
rtl/sts_chk.sv
sim/sine_taylor_partial_sums_tb.sv
